// ===== sv/assert_macros.svh =====
// ---------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assertion on an explicit clock and reset.
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Assertion on the block clock and reset.
`define ASSERT_STD(label, prop, msg) \
   `ASSERT_CLK(label, clock, reset, prop, msg)

`endif

// ===== sv/bpf_pkg.sv =====
// ---------------------------------------------------------------------------
// bpf_pkg
// Request and status codes of the byte pipe.
// ---------------------------------------------------------------------------
`default_nettype none

package bpf_pkg;

   typedef logic [2:0] req_kind_type;
   typedef logic [2:0] status_type;

   localparam req_kind_type REQ_OPEN      = 3'd0;
   localparam req_kind_type REQ_WRITE     = 3'd1;
   localparam req_kind_type REQ_READ      = 3'd2;
   localparam req_kind_type REQ_CLOSE_RD  = 3'd3;
   localparam req_kind_type REQ_CLOSE_WR  = 3'd4;

   localparam status_type ST_OK        = 3'd0;
   localparam status_type ST_WAIT_EMPT = 3'd1;
   localparam status_type ST_EOD       = 3'd2;
   localparam status_type ST_SHORT     = 3'd3;
   localparam status_type ST_WAIT_FULL = 3'd4;
   localparam status_type ST_BROKEN    = 3'd5;

endpackage

`default_nettype wire

// ===== sv/bpf_ram.sv =====
// ---------------------------------------------------------------------------
// bpf_ram
// Byte store: one write port, one read port with registered, enabled read.
// ---------------------------------------------------------------------------
`default_nettype none

module bpf_ram #(
   parameter int DEPTH  = 512,
   parameter int ADDR_W = 9
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [7:0]        wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [7:0]        rd_data
);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== sv/byte_pipe_fifo_core.sv =====
// ---------------------------------------------------------------------------
// byte_pipe_fifo_core
// Single byte pipe: ring buffer with read/write counters and end flags.
// ---------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  req      in         req_valid/req_ready    req_type, req_write_data,
//                                             req_first_of_call
//  rsp      out        rsp_valid/rsp_ready    rsp_status, rsp_read_data,
//                                             rsp_fill_level
//
//  One word per cycle sustained while rsp_ready stays high; a req word
//  goes through the request register, then the result register. Decision
//  and counter update sit between the two; the store read lands in
//  the RAM's own read register alongside the result.
//  Reset clears counters, end flags and valids; the byte store is not cleared.
//  A stalled rsp holds stage 1; req_ready drops only when both are full.
//
`default_nettype none

`include "assert_macros.svh"

module byte_pipe_fifo_core #(
   parameter int BUFFER_DEPTH = 512
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_ready,
   input  wire logic [2:0]                         req_type,
   input  wire logic [7:0]                         req_write_data,
   input  wire logic                               req_first_of_call,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic [2:0]                              rsp_status,
   output logic [7:0]                              rsp_read_data,
   output logic [$clog2(BUFFER_DEPTH):0]           rsp_fill_level
);

   // counters run modulo 2*depth, so one extra bit over the address
   localparam int CNT_W  = $clog2(BUFFER_DEPTH) + 1;
   localparam int ADDR_W = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
   localparam logic [CNT_W-1:0] DEPTH_C   = CNT_W'(BUFFER_DEPTH);
   localparam logic [CNT_W-1:0] CNT_LAST  = CNT_W'(2 * BUFFER_DEPTH - 1);
   localparam logic [CNT_W:0]   TWO_DEPTH = (CNT_W + 1)'(2 * BUFFER_DEPTH);

   // stage 1: request register
   logic                  s1_vld_ff;
   bpf_pkg::req_kind_type s1_type_ff;
   logic [7:0]            s1_wdata_ff;
   logic                  s1_first_ff;

   // pipe state
   logic [CNT_W-1:0] rd_cnt_ff, rd_cnt_in;
   logic [CNT_W-1:0] wr_cnt_ff, wr_cnt_in;
   logic             rd_open_ff, rd_open_in;
   logic             wr_open_ff, wr_open_in;

   // result register
   logic                 rsp_vld_ff;
   bpf_pkg::status_type  rsp_status_ff, rsp_status_in;
   logic [CNT_W-1:0]     rsp_fill_ff, rsp_fill_in;
   logic                 rsp_rd_ok_ff;

   logic             adv;
   logic             do_wr, do_rd;
   logic [CNT_W:0]   diff;
   logic [CNT_W-1:0] held;
   logic [CNT_W-1:0] wr_slot, rd_slot;
   logic [7:0]       ram_q;

   // stage 1 moves on whenever the result register is free or being taken
   assign adv       = !rsp_vld_ff || rsp_ready;
   assign req_ready = !s1_vld_ff || adv;

   // fill level, wrapped modulo 2*depth
   assign diff = {1'b0, wr_cnt_ff} - {1'b0, rd_cnt_ff};
   assign held = diff[CNT_W] ? CNT_W'(diff + TWO_DEPTH) : diff[CNT_W-1:0];

   assign wr_slot = (wr_cnt_ff >= DEPTH_C) ? (wr_cnt_ff - DEPTH_C) : wr_cnt_ff;
   assign rd_slot = (rd_cnt_ff >= DEPTH_C) ? (rd_cnt_ff - DEPTH_C) : rd_cnt_ff;

   always_comb begin
      rsp_status_in = bpf_pkg::ST_OK;
      do_wr         = 1'b0;
      do_rd         = 1'b0;
      rd_open_in    = rd_open_ff;
      wr_open_in    = wr_open_ff;
      unique case (s1_type_ff)
         bpf_pkg::REQ_OPEN: begin
            rd_open_in = 1'b1;
            wr_open_in = 1'b1;
         end
         bpf_pkg::REQ_WRITE: begin
            if (!rd_open_ff) begin
               rsp_status_in = bpf_pkg::ST_BROKEN;
            end else if (held >= DEPTH_C) begin
               rsp_status_in = bpf_pkg::ST_WAIT_FULL;
            end else begin
               do_wr = 1'b1;
            end
         end
         bpf_pkg::REQ_READ: begin
            if (held == '0) begin
               if (!s1_first_ff) begin
                  rsp_status_in = bpf_pkg::ST_SHORT;
               end else if (wr_open_ff) begin
                  rsp_status_in = bpf_pkg::ST_WAIT_EMPT;
               end else begin
                  rsp_status_in = bpf_pkg::ST_EOD;
               end
            end else begin
               do_rd = 1'b1;
            end
         end
         bpf_pkg::REQ_CLOSE_RD: rd_open_in = 1'b0;
         bpf_pkg::REQ_CLOSE_WR: wr_open_in = 1'b0;
         default: ;  // unknown request: no effect
      endcase
   end

   // next counters and the level they leave behind
   always_comb begin
      rd_cnt_in   = rd_cnt_ff;
      wr_cnt_in   = wr_cnt_ff;
      rsp_fill_in = held;
      if (s1_type_ff == bpf_pkg::REQ_OPEN) begin
         rd_cnt_in   = '0;
         wr_cnt_in   = '0;
         rsp_fill_in = '0;
      end else if (do_wr) begin
         wr_cnt_in   = (wr_cnt_ff == CNT_LAST) ? '0 : wr_cnt_ff + 1'b1;
         rsp_fill_in = held + 1'b1;
      end else if (do_rd) begin
         rd_cnt_in   = (rd_cnt_ff == CNT_LAST) ? '0 : rd_cnt_ff + 1'b1;
         rsp_fill_in = held - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
      end else if (req_ready) begin
         s1_vld_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_type_ff  <= req_type;
         s1_wdata_ff <= req_write_data;
         s1_first_ff <= req_first_of_call;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_cnt_ff  <= '0;
         wr_cnt_ff  <= '0;
         rd_open_ff <= 1'b0;
         wr_open_ff <= 1'b0;
      end else if (adv && s1_vld_ff) begin
         rd_cnt_ff  <= rd_cnt_in;
         wr_cnt_ff  <= wr_cnt_in;
         rd_open_ff <= rd_open_in;
         wr_open_ff <= wr_open_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_vld_ff <= 1'b0;
      end else if (adv) begin
         rsp_vld_ff <= s1_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && s1_vld_ff) begin
         rsp_status_ff <= rsp_status_in;
         rsp_fill_ff   <= rsp_fill_in;
         rsp_rd_ok_ff  <= do_rd;
      end
   end

   bpf_ram #(
      .DEPTH  (BUFFER_DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .wr_en   (adv && s1_vld_ff && do_wr),
      .wr_addr (wr_slot[ADDR_W-1:0]),
      .wr_data (s1_wdata_ff),
      .rd_en   (adv && s1_vld_ff && do_rd),
      .rd_addr (rd_slot[ADDR_W-1:0]),
      .rd_data (ram_q)
   );

   assign rsp_valid      = rsp_vld_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_read_data  = ram_q & {8{rsp_rd_ok_ff}};
   assign rsp_fill_level = rsp_fill_ff;

   `ASSERT_STD(a_held_bound, (held <= DEPTH_C), "fill level above buffer depth")
   `ASSERT_STD(a_cnt_bound,
      (rd_cnt_ff <= CNT_LAST && wr_cnt_ff <= CNT_LAST),
      "counter out of range")
   `ASSERT_STD(a_full_level,
      (rsp_vld_ff && rsp_status_ff == bpf_pkg::ST_WAIT_FULL |-> rsp_fill_ff == DEPTH_C),
      "wait full without full buffer")
   `ASSERT_STD(a_no_rd_on_err,
      (rsp_vld_ff && rsp_status_ff != bpf_pkg::ST_OK |-> !rsp_rd_ok_ff),
      "read data flagged on failed request")
   `ASSERT_STD(a_s1_hold,
      (s1_vld_ff && !adv |=> s1_vld_ff && $stable(s1_type_ff)),
      "stage 1 lost while stalled")

endmodule

`default_nettype wire
